// ===== sv/ffa_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
`timescale 1ns / 1ps

package ffa_pkg;

    // Fixed field widths of the request and result beats.
    localparam int REQ_W     = 16;
    localparam int OFF_W     = 14;
    localparam int STATUS_W  = 3;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 16;

    // Block sizes are kept in multiples of this many bytes.
    localparam int ALIGN_BYTES = 4;

    // Request kinds carried in the input tuser.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 3'd0,
        ST_ZERO_SIZE = 3'd1,
        ST_NO_MEMORY = 3'd2,
        ST_FREED     = 3'd3,
        ST_IGNORED   = 3'd4
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_AL_CHK,
        S_AL_SPLIT,
        S_FR_CHK,
        S_CO_RD0,
        S_CO_CUR,
        S_CO_EVAL,
        S_CO_NXT,
        S_DONE
    } t_state;

    // Memory port strobes from the sequencer.
    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

    // One result item.
    typedef struct packed {
        t_status           status;
        logic [OFF_W-1:0]  payload;
    } t_result;

endpackage

// ===== sv/ffa_mem.sv =====
// Block header memory: size and free mark per 4-byte slot, one read and one write port.
`timescale 1ns / 1ps

module ffa_mem #(
    parameter int HEAP_BYTES = 16384
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  ffa_pkg::t_mem_ctl                             i_ctl,
    input  logic [$clog2((HEAP_BYTES + 3) / 4)-1:0]       i_rd_addr,
    input  logic [$clog2((HEAP_BYTES + 3) / 4)-1:0]       i_wr_addr,
    input  logic [$clog2(HEAP_BYTES + 1)-1:0]             i_wr_size,
    input  logic                                          i_wr_free,
    output logic [$clog2(HEAP_BYTES + 1)-1:0]             o_rd_size,
    output logic                                          o_rd_free
);

    localparam int SLOTS  = (HEAP_BYTES + 3) / 4;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int SIZE_W = $clog2(HEAP_BYTES + 1);

    logic [SIZE_W:0] r_mem [SLOTS];
    logic [SIZE_W:0] r_rd_word;
    logic            r_init;
    logic            r_zero_hit;

    // Storage array: free mark in the top bit, size below it.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= {i_wr_free, i_wr_size};
        end
        if (i_ctl.rd) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    // Until slot 0 is first written it reads as one free block spanning the heap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init     <= 1'b1;
            r_zero_hit <= 1'b0;
        end else begin
            if (i_ctl.wr && (i_wr_addr == ADDR_W'(0))) begin
                r_init <= 1'b0;
            end
            if (i_ctl.rd) begin
                r_zero_hit <= r_init && (i_rd_addr == ADDR_W'(0));
            end
        end
    end

    assign o_rd_size = r_zero_hit ? SIZE_W'(HEAP_BYTES) : r_rd_word[SIZE_W-1:0];
    assign o_rd_free = r_zero_hit ? 1'b1 : r_rd_word[SIZE_W];

endmodule

// ===== sv/ffa_seq.sv =====
// Request sequencer: chain walks for allocate and free, split and coalescing pass.
`timescale 1ns / 1ps

module ffa_seq #(
    parameter int HEAP_BYTES   = 16384,
    parameter int HEADER_BYTES = 12
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_in_valid,
    output logic                                          o_in_ready,
    input  logic                                          i_action,
    input  logic [ffa_pkg::REQ_W-1:0]                     i_req_size,
    input  logic [ffa_pkg::OFF_W-1:0]                     i_free_off,
    output ffa_pkg::t_mem_ctl                             o_mem_ctl,
    output logic [$clog2((HEAP_BYTES + 3) / 4)-1:0]       o_rd_addr,
    output logic [$clog2((HEAP_BYTES + 3) / 4)-1:0]       o_wr_addr,
    output logic [$clog2(HEAP_BYTES + 1)-1:0]             o_wr_size,
    output logic                                          o_wr_free,
    input  logic [$clog2(HEAP_BYTES + 1)-1:0]             i_rd_size,
    input  logic                                          i_rd_free,
    output logic                                          o_res_valid,
    input  logic                                          i_res_ready,
    output ffa_pkg::t_result                              o_res
);

    localparam int SLOTS  = (HEAP_BYTES + 3) / 4;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int SIZE_W = $clog2(HEAP_BYTES + 1);
    // Byte arithmetic width: covers heap positions and the largest rounded request.
    localparam int CMP_W  = ((SIZE_W > ffa_pkg::REQ_W + 1) ? SIZE_W : ffa_pkg::REQ_W + 1) + 1;

    localparam logic [CMP_W-1:0] HEAP_C   = CMP_W'(HEAP_BYTES);
    localparam logic [CMP_W-1:0] HDR_C    = CMP_W'(HEADER_BYTES);
    localparam logic [CMP_W-1:0] ALIGN_C  = CMP_W'(ffa_pkg::ALIGN_BYTES);

    ffa_pkg::t_state  r_state, n_state;
    logic [CMP_W-1:0] r_pos, n_pos;
    logic [CMP_W-1:0] r_total, n_total;
    logic [CMP_W-1:0] r_target, n_target;
    logic [SIZE_W-1:0] r_sz, n_sz;
    logic             r_fr, n_fr;
    ffa_pkg::t_status r_status, n_status;
    logic [ffa_pkg::OFF_W-1:0] r_payload, n_payload;

    logic             w_accept;
    logic [CMP_W-1:0] w_total;
    logic             w_zero_req;
    logic             w_null_free;
    logic [CMP_W-1:0] w_rd_sz;
    logic [CMP_W-1:0] w_nxt;
    logic             w_rd_zero;
    logic             w_fit;
    logic             w_split;
    logic             w_nxt_end;
    logic [CMP_W-1:0] w_cnx;
    logic             w_co_stop;
    logic             w_merge;
    logic [CMP_W-1:0] w_split_pos;
    logic [CMP_W-1:0] w_pay_full;

    // Shared decision terms.
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_total     = (CMP_W'(i_req_size) + HDR_C + (ALIGN_C - CMP_W'(1)))
                         & ~(ALIGN_C - CMP_W'(1));
    assign w_zero_req  = (i_req_size == ffa_pkg::REQ_W'(0));
    assign w_null_free = (i_free_off == ffa_pkg::OFF_W'(0)) || (CMP_W'(i_free_off) < HDR_C);
    assign w_rd_sz     = CMP_W'(i_rd_size);
    assign w_nxt       = r_pos + w_rd_sz;
    assign w_rd_zero   = (i_rd_size == SIZE_W'(0));
    assign w_fit       = i_rd_free && (w_rd_sz >= r_total);
    assign w_split     = w_rd_sz >= (r_total + HDR_C + ALIGN_C);
    assign w_nxt_end   = (w_nxt >= HEAP_C);
    assign w_cnx       = r_pos + CMP_W'(r_sz);
    assign w_co_stop   = (r_sz == SIZE_W'(0)) || (w_cnx >= HEAP_C);
    assign w_merge     = r_fr && i_rd_free && !w_rd_zero;
    assign w_split_pos = r_pos + r_total;
    assign w_pay_full  = r_pos + HDR_C;

    assign o_in_ready  = (r_state == ffa_pkg::S_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffa_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_action == ffa_pkg::ACT_ALLOC) begin
                        n_state = w_zero_req ? ffa_pkg::S_DONE : ffa_pkg::S_AL_CHK;
                    end else begin
                        n_state = w_null_free ? ffa_pkg::S_DONE : ffa_pkg::S_FR_CHK;
                    end
                end
            end
            ffa_pkg::S_AL_CHK: begin
                if (w_rd_zero) begin
                    n_state = ffa_pkg::S_DONE;
                end else if (w_fit) begin
                    n_state = w_split ? ffa_pkg::S_AL_SPLIT : ffa_pkg::S_DONE;
                end else if (w_nxt_end) begin
                    n_state = ffa_pkg::S_DONE;
                end
            end
            ffa_pkg::S_AL_SPLIT: n_state = ffa_pkg::S_DONE;
            ffa_pkg::S_FR_CHK: begin
                if (w_rd_zero) begin
                    n_state = ffa_pkg::S_DONE;
                end else if (r_pos == r_target) begin
                    n_state = ffa_pkg::S_CO_RD0;
                end else if (w_nxt_end || (w_nxt > r_target)) begin
                    n_state = ffa_pkg::S_DONE;
                end
            end
            ffa_pkg::S_CO_RD0: n_state = ffa_pkg::S_CO_CUR;
            ffa_pkg::S_CO_CUR: n_state = ffa_pkg::S_CO_EVAL;
            ffa_pkg::S_CO_EVAL: n_state = w_co_stop ? ffa_pkg::S_DONE : ffa_pkg::S_CO_NXT;
            ffa_pkg::S_CO_NXT: n_state = ffa_pkg::S_CO_EVAL;
            ffa_pkg::S_DONE: begin
                if (i_res_ready) begin
                    n_state = ffa_pkg::S_IDLE;
                end
            end
            default: n_state = ffa_pkg::S_IDLE;
        endcase
    end

    // Datapath updates and memory accesses.
    always_comb begin
        n_pos       = r_pos;
        n_total     = r_total;
        n_target    = r_target;
        n_sz        = r_sz;
        n_fr        = r_fr;
        n_status    = r_status;
        n_payload   = r_payload;
        o_mem_ctl   = '0;
        o_rd_addr   = ADDR_W'(0);
        o_wr_addr   = r_pos[ADDR_W+1:2];
        o_wr_size   = i_rd_size;
        o_wr_free   = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            ffa_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_pos     = '0;
                    n_total   = w_total;
                    n_target  = CMP_W'(i_free_off) - HDR_C;
                    n_payload = '0;
                    if (i_action == ffa_pkg::ACT_ALLOC) begin
                        n_status      = w_zero_req ? ffa_pkg::ST_ZERO_SIZE
                                                   : ffa_pkg::ST_NO_MEMORY;
                        o_mem_ctl.rd  = !w_zero_req;
                    end else begin
                        n_status      = ffa_pkg::ST_IGNORED;
                        o_mem_ctl.rd  = !w_null_free;
                    end
                end
            end
            ffa_pkg::S_AL_CHK: begin
                if (w_rd_zero) begin
                    n_status = ffa_pkg::ST_NO_MEMORY;
                end else if (w_fit) begin
                    n_status     = ffa_pkg::ST_ALLOCATED;
                    n_payload    = w_pay_full[ffa_pkg::OFF_W-1:0];
                    o_mem_ctl.wr = 1'b1;
                    if (w_split) begin
                        // Leftover becomes a new free block behind the taken one.
                        o_wr_addr = w_split_pos[ADDR_W+1:2];
                        o_wr_size = i_rd_size - r_total[SIZE_W-1:0];
                        o_wr_free = 1'b1;
                    end
                end else if (!w_nxt_end) begin
                    n_pos        = w_nxt;
                    o_mem_ctl.rd = 1'b1;
                    o_rd_addr    = w_nxt[ADDR_W+1:2];
                end
            end
            ffa_pkg::S_AL_SPLIT: begin
                o_mem_ctl.wr = 1'b1;
                o_wr_size    = r_total[SIZE_W-1:0];
                o_wr_free    = 1'b0;
            end
            ffa_pkg::S_FR_CHK: begin
                if (!w_rd_zero) begin
                    if (r_pos == r_target) begin
                        o_mem_ctl.wr = 1'b1;
                        o_wr_free    = 1'b1;
                    end else if (!(w_nxt_end || (w_nxt > r_target))) begin
                        n_pos        = w_nxt;
                        o_mem_ctl.rd = 1'b1;
                        o_rd_addr    = w_nxt[ADDR_W+1:2];
                    end
                end
            end
            ffa_pkg::S_CO_RD0: begin
                n_pos        = '0;
                o_mem_ctl.rd = 1'b1;
            end
            ffa_pkg::S_CO_CUR: begin
                n_sz = i_rd_size;
                n_fr = i_rd_free;
            end
            ffa_pkg::S_CO_EVAL: begin
                if (w_co_stop) begin
                    n_status = ffa_pkg::ST_FREED;
                end else begin
                    o_mem_ctl.rd = 1'b1;
                    o_rd_addr    = w_cnx[ADDR_W+1:2];
                end
            end
            ffa_pkg::S_CO_NXT: begin
                if (w_merge) begin
                    // Absorb the successor and look again from the same block.
                    n_sz         = r_sz + i_rd_size;
                    o_mem_ctl.wr = 1'b1;
                    o_wr_size    = r_sz + i_rd_size;
                    o_wr_free    = 1'b1;
                end else begin
                    n_pos = w_cnx;
                    n_sz  = i_rd_size;
                    n_fr  = i_rd_free;
                end
            end
            ffa_pkg::S_DONE: begin
                o_res_valid = i_res_ready;
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    assign o_res.status  = r_status;
    assign o_res.payload = r_payload;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Walk registers.
    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_total   <= n_total;
        r_target  <= n_target;
        r_sz      <= n_sz;
        r_fr      <= n_fr;
        r_status  <= n_status;
        r_payload <= n_payload;
    end

    // The sequencer never reads and writes the memory in the same cycle.
    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_ctl.rd && o_mem_ctl.wr))
        else $error("memory read and write issued together");

    // An accepted request always leaves the idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ffa_pkg::S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // Only a successful allocation carries a payload offset.
    a_pay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status != ffa_pkg::ST_ALLOCATED)) |-> (o_res.payload == '0))
        else $error("nonzero payload on a result that is not an allocation");

    // A result is only issued from the done state.
    a_res_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_state == ffa_pkg::S_DONE))
        else $error("result issued outside the done state");

endmodule

// ===== sv/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator: stream ports, output register, memory and sequencer.
// Zero-size requests and null frees go straight to the done state; an allocate reads the chain
// one header per cycle until it finds a fit, a zero-size header or the end of the heap.
// A free walks to its block one header per cycle, then runs the coalescing pass from the heap
// start; one request is in flight at a time.
// The next request is taken while a finished result still waits in the output register.
// Reset is synchronous and active low; the header memory needs no clearing pass.
`timescale 1ns / 1ps

module first_fit_heap_allocator_top #(
    parameter int HEAP_BYTES   = 16384,
    parameter int HEADER_BYTES = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [15:0] request_size, [29:16] free_offset, [31:30] zero
    input  logic [ffa_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // [0] action
    input  logic [0:0]                        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [13:0] payload_offset, [15:14] zero
    output logic [ffa_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // [2:0] status
    output logic [ffa_pkg::STATUS_W-1:0]      o_m_axis_tuser
);

    localparam int SLOTS  = (HEAP_BYTES + 3) / 4;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int SIZE_W = $clog2(HEAP_BYTES + 1);

    ffa_pkg::t_mem_ctl  w_mem_ctl;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [SIZE_W-1:0]  w_wr_size;
    logic               w_wr_free;
    logic [SIZE_W-1:0]  w_rd_size;
    logic               w_rd_free;
    logic               w_res_valid;
    logic               w_res_ready;
    ffa_pkg::t_result   w_res;

    logic               r_out_valid;
    ffa_pkg::t_result   r_out;

    ffa_mem #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_mem_ctl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr_size (w_wr_size),
        .i_wr_free (w_wr_free),
        .o_rd_size (w_rd_size),
        .o_rd_free (w_rd_free)
    );

    ffa_seq #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_action    (i_s_axis_tuser[0]),
        .i_req_size  (i_s_axis_tdata[15:0]),
        .i_free_off  (i_s_axis_tdata[29:16]),
        .o_mem_ctl   (w_mem_ctl),
        .o_rd_addr   (w_rd_addr),
        .o_wr_addr   (w_wr_addr),
        .o_wr_size   (w_wr_size),
        .o_wr_free   (w_wr_free),
        .i_rd_size   (w_rd_size),
        .i_rd_free   (w_rd_free),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // The output register can take a result when empty or emptying this cycle.
    assign w_res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = ffa_pkg::OUT_DATA_W'(r_out.payload);
    assign o_m_axis_tuser  = r_out.status;

    // A new result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (!r_out_valid || i_m_axis_tready))
        else $error("result overwrote a pending output beat");

endmodule

// ===== bench/first_fit_heap_allocator_top_test.sv =====
// Self-checking bench for the first-fit heap allocator: directed and random traffic with stalls.
`timescale 1ns / 1ps

module first_fit_heap_allocator_top_test;

    localparam int HEAP_SIZE      = 16384;
    localparam int HDR_SIZE       = 12;
    localparam int SLOT_COUNT     = HEAP_SIZE / ffa_pkg::ALIGN_BYTES;
    // No beat may be quiet longer than a full coalescing pass over a fragmented heap plus a stall.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 4000;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           o_s_axis_tready;
    // [15:0] request_size, [29:16] free_offset, [31:30] zero
    logic [ffa_pkg::IN_DATA_W-1:0]  s_tdata;
    // [0] action
    logic [0:0]                     s_tuser;
    logic                           o_m_axis_tvalid;
    logic                           m_tready;
    // [13:0] payload_offset, [15:14] zero
    logic [ffa_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    // [2:0] status
    logic [ffa_pkg::STATUS_W-1:0]   o_m_axis_tuser;

    // Mirror of the heap: block size and free mark per 4-byte slot.
    logic [14:0]           chain_size [SLOT_COUNT];
    logic                  chain_free [SLOT_COUNT];

    ffa_pkg::t_result           heap_replies_due [$];
    logic [ffa_pkg::OFF_W-1:0]  live_payloads [$];
    int                    mismatches;
    int                    quiet_cycles;
    int                    stall_span;
    bit                    sender_idles;
    bit                    receiver_idles;

    first_fit_heap_allocator_top #(
        .HEAP_BYTES   (HEAP_SIZE),
        .HEADER_BYTES (HDR_SIZE)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // 100 MHz clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Heap mirror accessors; a position past the heap reads as an empty, used slot.
    function automatic int unsigned size_at(int unsigned pos);
        return (pos / ffa_pkg::ALIGN_BYTES < SLOT_COUNT) ?
               chain_size[pos / ffa_pkg::ALIGN_BYTES] : 0;
    endfunction

    function automatic bit free_at(int unsigned pos);
        return (pos / ffa_pkg::ALIGN_BYTES < SLOT_COUNT) ?
               chain_free[pos / ffa_pkg::ALIGN_BYTES] : 1'b0;
    endfunction

    function automatic void put_block(int unsigned pos, int unsigned size, bit is_free);
        if (pos / ffa_pkg::ALIGN_BYTES < SLOT_COUNT) begin
            chain_size[pos / ffa_pkg::ALIGN_BYTES] = size[14:0];
            chain_free[pos / ffa_pkg::ALIGN_BYTES] = is_free;
        end
    endfunction

    function automatic void heap_clear();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            chain_size[i] = '0;
            chain_free[i] = 1'b0;
        end
        put_block(0, HEAP_SIZE, 1'b1);
    endfunction

    // Merge every adjacent pair of free blocks, restarting at a block after each merge.
    function automatic void merge_free_neighbors();
        int unsigned pos;
        int unsigned sz;
        int unsigned nxt;
        pos = 0;
        while (pos < HEAP_SIZE) begin
            sz = size_at(pos);
            if (sz == 0) break;
            nxt = pos + sz;
            if (nxt >= HEAP_SIZE) break;
            if (free_at(pos) && free_at(nxt) && size_at(nxt) != 0)
                put_block(pos, sz + size_at(nxt), 1'b1);
            else
                pos = nxt;
        end
    endfunction

    // Apply one request to the heap mirror and return the reply the block must give.
    function automatic ffa_pkg::t_result serve_request(logic act,
                                                       logic [ffa_pkg::REQ_W-1:0] req,
                                                       logic [ffa_pkg::OFF_W-1:0] foff);
        ffa_pkg::t_result res;
        int unsigned pos;
        int unsigned sz;
        int unsigned total;
        int unsigned target;
        res.status  = ffa_pkg::ST_IGNORED;
        res.payload = '0;
        pos = 0;
        if (act == ffa_pkg::ACT_ALLOC) begin
            if (req == 0) begin
                res.status = ffa_pkg::ST_ZERO_SIZE;
            end else begin
                total = (int'(req) + HDR_SIZE + ffa_pkg::ALIGN_BYTES - 1) & ~32'd3;
                res.status = ffa_pkg::ST_NO_MEMORY;
                while (pos < HEAP_SIZE) begin
                    sz = size_at(pos);
                    if (sz == 0) break;
                    if (free_at(pos) && sz >= total) begin
                        // Split only when the leftover can hold a header and one word.
                        if (sz >= total + HDR_SIZE + ffa_pkg::ALIGN_BYTES) begin
                            put_block(pos + total, sz - total, 1'b1);
                            put_block(pos, total, 1'b0);
                        end else begin
                            put_block(pos, sz, 1'b0);
                        end
                        res.payload = ffa_pkg::OFF_W'(pos + HDR_SIZE);
                        res.status  = ffa_pkg::ST_ALLOCATED;
                        break;
                    end
                    pos += sz;
                end
            end
        end else if (foff != 0 && foff >= HDR_SIZE) begin
            target = foff - HDR_SIZE;
            while (pos < HEAP_SIZE && pos <= target) begin
                sz = size_at(pos);
                if (sz == 0) break;
                if (pos == target) begin
                    put_block(pos, sz, 1'b1);
                    merge_free_neighbors();
                    res.status = ffa_pkg::ST_FREED;
                    break;
                end
                pos += sz;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Send one request beat and record the reply it must produce.
    task automatic send_request(input logic act, input logic [ffa_pkg::REQ_W-1:0] req,
                                input logic [ffa_pkg::OFF_W-1:0] foff,
                                output ffa_pkg::t_status outcome);
        int               gap;
        ffa_pkg::t_result reply;
        gap = sender_idles ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, foff, req};
        s_tuser  <= act;
        do @(posedge clk); while (!o_s_axis_tready);
        reply = serve_request(act, req, foff);
        heap_replies_due.push_back(reply);
        if (act == ffa_pkg::ACT_ALLOC && reply.status == ffa_pkg::ST_ALLOCATED)
            live_payloads.push_back(reply.payload);
        outcome = reply.status;
    endtask

    // Mostly allocations and frees of live blocks, with zero sizes, oversize
    // requests, null frees and frees of offsets that start no block mixed in.
    task automatic run_mixed_traffic(int count);
        int                        pick;
        int                        idx;
        logic                      act;
        logic [ffa_pkg::REQ_W-1:0] req;
        logic [ffa_pkg::OFF_W-1:0] foff;
        ffa_pkg::t_status          outcome;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            act  = ffa_pkg::ACT_ALLOC;
            req  = ffa_pkg::REQ_W'($urandom_range(0, 65535));
            foff = ffa_pkg::OFF_W'($urandom_range(0, 16383));
            if (pick < 85 && (pick < 50 || live_payloads.size() == 0)) begin
                case ($urandom_range(0, 9))
                    0:       req = ffa_pkg::REQ_W'($urandom_range(0, 65535));
                    1, 2:    req = ffa_pkg::REQ_W'($urandom_range(200, 2000));
                    default: req = ffa_pkg::REQ_W'($urandom_range(1, 200));
                endcase
            end else if (pick < 85) begin
                act  = ffa_pkg::ACT_FREE;
                idx  = $urandom_range(0, live_payloads.size() - 1);
                foff = live_payloads[idx];
                live_payloads.delete(idx);
            end else if (pick < 90) begin
                act = ffa_pkg::ACT_FREE;
            end else if (pick < 95) begin
                act = pick[0] ? ffa_pkg::ACT_FREE : ffa_pkg::ACT_ALLOC;
                req  = '0;
                foff = '0;
            end else begin
                // Offsets inside a live block, or below the header size.
                act = ffa_pkg::ACT_FREE;
                if (live_payloads.size() != 0 && pick[0])
                    foff = live_payloads[$urandom_range(0, live_payloads.size() - 1)] +
                           ffa_pkg::OFF_W'(ffa_pkg::ALIGN_BYTES);
                else
                    foff = ffa_pkg::OFF_W'($urandom_range(1, HDR_SIZE - 1));
            end
            send_request(act, req, foff, outcome);
        end
    endtask

    task automatic test_directed_cases();
        ffa_pkg::t_status outcome;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        // Zero size refused, null free, offset under the header, larger than the heap.
        send_request(ffa_pkg::ACT_ALLOC, 16'd0,     14'd0,    outcome);
        send_request(ffa_pkg::ACT_FREE,  16'd0,     14'd0,    outcome);
        send_request(ffa_pkg::ACT_FREE,  16'd0,     14'd5,    outcome);
        send_request(ffa_pkg::ACT_ALLOC, 16'hFFFF,  14'd0,    outcome);
        // Whole heap without a split, then a walk that runs off the heap end.
        send_request(ffa_pkg::ACT_ALLOC, 16'd16372, 14'd0,    outcome);
        send_request(ffa_pkg::ACT_ALLOC, 16'd1,     14'd0,    outcome);
        // Top offset that is not a block, a free and a double free.
        send_request(ffa_pkg::ACT_FREE,  16'hFFFF,  14'h3FFF, outcome);
        send_request(ffa_pkg::ACT_FREE,  16'd0,     14'd12,   outcome);
        send_request(ffa_pkg::ACT_FREE,  16'd0,     14'd12,   outcome);
        // Smallest block with a split, then a free inside a block.
        send_request(ffa_pkg::ACT_ALLOC, 16'd1,     14'd0,    outcome);
        send_request(ffa_pkg::ACT_ALLOC, 16'd4,     14'd0,    outcome);
        send_request(ffa_pkg::ACT_FREE,  16'd0,     14'd13,   outcome);
        // Leftover too small to split, then a full heap.
        send_request(ffa_pkg::ACT_ALLOC, 16'd16328, 14'd0,    outcome);
        send_request(ffa_pkg::ACT_ALLOC, 16'd1,     14'd0,    outcome);
        // Neighbors both in use, a forward merge, a merge back to one block.
        send_request(ffa_pkg::ACT_FREE,  16'd0,     14'd28,   outcome);
        send_request(ffa_pkg::ACT_FREE,  16'd0,     14'd12,   outcome);
        send_request(ffa_pkg::ACT_FREE,  16'd0,     14'd44,   outcome);
        send_request(ffa_pkg::ACT_ALLOC, 16'd16372, 14'd0,    outcome);
        send_request(ffa_pkg::ACT_FREE,  16'd0,     14'd12,   outcome);
        live_payloads.delete();
    endtask

    task automatic test_random_traffic();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        run_mixed_traffic(500);
    endtask

    task automatic test_back_to_back();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        run_mixed_traffic(300);
    endtask

    // The result side stops for a long stretch while requests keep coming.
    task automatic test_output_stall();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        stall_span     = 300;
        run_mixed_traffic(40);
    endtask

    // Fragment the heap with small blocks until it runs out, then free all in random order.
    task automatic test_fill_and_drain();
        int               n;
        int               idx;
        ffa_pkg::t_status outcome;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        n = 0;
        outcome = ffa_pkg::ST_ALLOCATED;
        while (outcome != ffa_pkg::ST_NO_MEMORY && n < 400) begin
            send_request(ffa_pkg::ACT_ALLOC, ffa_pkg::REQ_W'($urandom_range(8, 128)), '0,
                         outcome);
            n++;
        end
        while (live_payloads.size() != 0) begin
            idx = $urandom_range(0, live_payloads.size() - 1);
            send_request(ffa_pkg::ACT_FREE, '0, live_payloads[idx], outcome);
            live_payloads.delete(idx);
        end
    endtask

    // Result side: a random hold-off before each beat, or one long stall on request.
    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            gap = receiver_idles ? $urandom_range(0, 4) : 0;
            if (stall_span > 0) begin
                gap        = stall_span;
                stall_span = 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(o_m_axis_tvalid && m_tready));
        end
    end

    // Compare every result beat with the oldest outstanding reply.
    always @(posedge clk) begin : result_check
        ffa_pkg::t_result want;
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            if (heap_replies_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d data %0h",
                                          o_m_axis_tuser, o_m_axis_tdata));
            end else begin
                want = heap_replies_due.pop_front();
                if (o_m_axis_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_m_axis_tuser, want.status));
                if (o_m_axis_tdata !==
                    {{(ffa_pkg::OUT_DATA_W - ffa_pkg::OFF_W){1'b0}}, want.payload})
                    report_mismatch($sformatf("payload offset %0d, want %0d",
                                              o_m_axis_tdata, want.payload));
            end
        end
    end

    // Stop a hung run: count cycles in which neither side moves a beat.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Test sequence.
    initial begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = ffa_pkg::ACT_ALLOC;
        mismatches     = 0;
        quiet_cycles   = 0;
        stall_span     = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        heap_clear();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic();
        test_back_to_back();
        test_output_stall();
        test_fill_and_drain();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (heap_replies_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
